// ===== sv/cets_pkg.sv =====
package cets_pkg;

    localparam int VALUE_W     = 15;
    localparam int DUTY_W      = 7;
    localparam int INDEX_W     = 7;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int TABLE_DEPTH_DEF = 128;

    localparam logic [VALUE_W-1:0] CEILING_RST = 15'd32767;
    localparam logic [COUNT_W-1:0] COUNT_RST   = 8'd128;
    localparam logic               DESC_RST    = 1'b0;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESC    = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] entry_index;
        logic [VALUE_W-1:0] entry_value;
        logic [DUTY_W-1:0]  entry_duty;
        logic [VALUE_W-1:0] request;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] match_index;
        logic [VALUE_W-1:0] match_value;
        logic [DUTY_W-1:0]  match_duty;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_PROBE
    } t_state;

endpackage

// ===== sv/cets_stream_if.sv =====
interface cets_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/closest_entry_table_search.sv =====
// Nearest-entry search over a sorted calibration table.
// i_in: one beat per item. cmd load writes value and duty at entry_index
//   (indexes at or above TABLE_DEPTH are dropped) and gives no result.
//   cmd lookup clamps request to the ceiling, binary-searches the first
//   entries_in_use entries and returns one o_out beat: nearest index,
//   value and duty; ties keep the earlier candidate, an exact hit stops.
// i_cfg: register writes (0 ceiling, 1 entry count, 2 descending), always
//   ready; write only while no lookup is in flight.
// Timing: a lookup reads entry 0 as a seed and then runs P probes before
//   o_out.valid, P = 1..floor(log2(count))+1 (up to 8 for 128 entries).
//   Each probe is one read of the single table memory plus one compare,
//   so the probe loop through that read port sets the rate. i_in is ready
//   again in the cycle the result beat is first offered.
// Stall: the result sits in an output register until taken; the next item
//   is accepted meanwhile. A lookup finishing into a still-full register
//   holds its last probe until the register drains.
// Reset: config registers return to 32767 / 128 / ascending, no beat is
//   pending. Table contents are undefined until loaded.
module closest_entry_table_search #(
    parameter int TABLE_DEPTH = cets_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cets_stream_if.sink   i_in,
    cets_stream_if.source o_out,
    cets_stream_if.sink   i_cfg
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int W     = IDX_W + 2;
    localparam int MEM_W = cets_pkg::VALUE_W + cets_pkg::DUTY_W;
    localparam int VW    = cets_pkg::VALUE_W;
    localparam int DW    = cets_pkg::DUTY_W;
    localparam int XW    = IDX_W + cets_pkg::INDEX_W;

    logic [MEM_W-1:0] r_mem [TABLE_DEPTH];
    logic [MEM_W-1:0] r_rd;

    cets_pkg::t_state    r_state, n_state;
    logic signed [W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [IDX_W-1:0]    r_mid, n_mid;
    logic [VW-1:0]       r_target, n_target;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [VW-1:0]       r_best_val, n_best_val;
    logic [DW-1:0]       r_best_duty, n_best_duty;
    logic [VW-1:0]       r_best_dist, n_best_dist;
    logic                r_out_valid, n_out_valid;
    cets_pkg::t_out_item r_out, n_out;

    logic [VW-1:0]          r_ceiling;
    logic [cets_pkg::COUNT_W-1:0] r_count;
    logic                   r_desc;

    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    logic [XW-1:0]    wr_ext;
    logic [XW-1:0]    mid_ext;
    logic [XW-1:0]    best_ext;

    logic [VW-1:0]       rd_val;
    logic [DW-1:0]       rd_duty;
    logic [VW-1:0]       rd_dist;
    logic                better, hit, go_up, done;
    logic signed [W-1:0] mid_s, lo2, hi2, sum;

    assign rd_val  = r_rd[MEM_W-1:DW];
    assign rd_duty = r_rd[DW-1:0];
    assign rd_dist = (rd_val > r_target) ? (rd_val - r_target) : (r_target - rd_val);
    assign better  = rd_dist < r_best_dist;
    assign hit     = rd_val == r_target;
    assign go_up   = r_desc ? (rd_val > r_target) : (rd_val < r_target);
    assign mid_s   = $signed({2'b00, r_mid});
    assign lo2     = go_up ? (mid_s + W'(1)) : r_lo;
    assign hi2     = go_up ? r_hi : (mid_s - W'(1));
    assign done    = hit || (lo2 > hi2);

    assign wr_ext   = {{IDX_W{1'b0}}, i_in.data.entry_index};
    assign wr_addr  = wr_ext[IDX_W-1:0];
    assign mid_ext  = {{cets_pkg::INDEX_W{1'b0}}, r_mid};
    assign best_ext = {{cets_pkg::INDEX_W{1'b0}}, r_best_idx};

    assign i_in.ready  = (r_state == cets_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= {i_in.data.entry_value, i_in.data.entry_duty};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_target    = r_target;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_best_duty = r_best_duty;
        n_best_dist = r_best_dist;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_addr     = r_mid;
        we          = 1'b0;
        sum         = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            cets_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.data.cmd == cets_pkg::CMD_LOAD) begin
                        we = wr_ext < XW'(TABLE_DEPTH);
                    end else begin
                        n_target = (i_in.data.request > r_ceiling) ? r_ceiling
                                                                   : i_in.data.request;
                        n_lo = '0;
                        if (32'(r_count) > 32'(TABLE_DEPTH)) begin
                            n_hi = W'(TABLE_DEPTH - 1);
                        end else if (r_count == '0) begin
                            n_hi = '0;
                        end else begin
                            n_hi = W'(32'(r_count) - 32'd1);
                        end
                        rd_addr = '0;
                        n_state = cets_pkg::ST_SEED;
                    end
                end
            end
            cets_pkg::ST_SEED: begin
                n_best_idx  = '0;
                n_best_val  = rd_val;
                n_best_duty = rd_duty;
                n_best_dist = rd_dist;
                sum         = r_lo + r_hi;
                n_mid       = IDX_W'(sum >>> 1);
                rd_addr     = n_mid;
                n_state     = cets_pkg::ST_PROBE;
            end
            cets_pkg::ST_PROBE: begin
                if (done) begin
                    if (!r_out_valid || o_out.ready) begin
                        n_out_valid = 1'b1;
                        if (hit || better) begin
                            n_out.match_index = mid_ext[cets_pkg::INDEX_W-1:0];
                            n_out.match_value = rd_val;
                            n_out.match_duty  = rd_duty;
                        end else begin
                            n_out.match_index = best_ext[cets_pkg::INDEX_W-1:0];
                            n_out.match_value = r_best_val;
                            n_out.match_duty  = r_best_duty;
                        end
                        n_state = cets_pkg::ST_IDLE;
                    end
                end else begin
                    if (better) begin
                        n_best_idx  = r_mid;
                        n_best_val  = rd_val;
                        n_best_duty = rd_duty;
                        n_best_dist = rd_dist;
                    end
                    n_lo    = lo2;
                    n_hi    = hi2;
                    sum     = lo2 + hi2;
                    n_mid   = IDX_W'(sum >>> 1);
                    rd_addr = n_mid;
                end
            end
            default: begin
                n_state = cets_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cets_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_target    <= n_target;
        r_best_idx  <= n_best_idx;
        r_best_val  <= n_best_val;
        r_best_duty <= n_best_duty;
        r_best_dist <= n_best_dist;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= cets_pkg::CEILING_RST;
            r_count   <= cets_pkg::COUNT_RST;
            r_desc    <= cets_pkg::DESC_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                cets_pkg::CFG_CEILING: r_ceiling <= i_cfg.data.data[VW-1:0];
                cets_pkg::CFG_COUNT:   r_count   <= i_cfg.data.data[cets_pkg::COUNT_W-1:0];
                cets_pkg::CFG_DESC:    r_desc    <= i_cfg.data.data[0];
                default: begin
                end
            endcase
        end
    end

    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cets_pkg::ST_PROBE) |-> (r_lo <= mid_s) && (mid_s <= r_hi))
        else $error("probe index outside search window");

    a_best_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cets_pkg::ST_PROBE) && ($past(r_state) == cets_pkg::ST_PROBE)
        |-> (r_best_dist <= $past(r_best_dist)))
        else $error("best distance grew during search");

    a_result_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cets_pkg::ST_PROBE) && done && !r_out_valid
        |=> r_out_valid && (r_state == cets_pkg::ST_IDLE))
        else $error("finished lookup produced no result beat");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cets_pkg::ST_IDLE) |-> !we)
        else $error("table written during a search");

endmodule
